/* design/assert_macros.svh */
// Assertion macros used by the search sequencer of the lookup unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock and disabled during reset.
`define STKL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clock and disabled during reset.
`define STKL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* design/stkl_pkg.sv */
// Types and constants shared by the sorted table lookup unit.
package stkl_pkg;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 64;
   localparam int INDEX_W = 12;
   localparam int SIZE_W  = 13;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] entry_index;
      logic [KEY_W-1:0]   search_key;
      logic [VALUE_W-1:0] entry_value;
   } stkl_req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] found_value;
   } stkl_rsp_type;

   typedef struct packed {
      logic             go;
      logic [KEY_W-1:0] search_key;
   } stkl_launch_type;

endpackage

/* design/stkl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module stkl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/stkl_search.sv */
// Search sequencer: bisection probes followed by a pipelined linear scan.
`include "assert_macros.svh"

module stkl_search #(
   parameter int TABLE_DEPTH = 4096,
   parameter int LINEAR_SPAN = 50
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  stkl_pkg::stkl_launch_type                launch,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]         size,
   input  logic [stkl_pkg::KEY_W-1:0]               rd_key,
   input  logic [stkl_pkg::VALUE_W-1:0]             rd_value,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
   output logic                                     busy,
   output logic                                     rsp_valid,
   output stkl_pkg::stkl_rsp_type                   rsp_item
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_BISECT = 3'b010,
      ST_SCAN   = 3'b100
   } stkl_state_type;

   stkl_state_type               state_ff, state_in;
   logic [CNT_W-1:0]             top_ff, top_in;
   logic [CNT_W-1:0]             bottom_ff, bottom_in;
   logic [CNT_W-1:0]             probe_ff, probe_in;
   logic [stkl_pkg::KEY_W-1:0]   key_ff, key_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   stkl_pkg::stkl_rsp_type       rsp_ff, rsp_in;

   logic                         key_match;
   logic                         go_up;
   logic                         span_short;
   logic [CNT_W-1:0]             span;
   logic [CNT_W:0]               bis_sum;
   logic [CNT_W-1:0]             mid_next;
   logic [CNT_W-1:0]             scan_next;
   logic [CNT_W-1:0]             launch_mid;

   // The read data on rd_key and rd_value always belongs to probe_ff.
   assign key_match  = (rd_key == key_ff);
   assign go_up      = (rd_key < key_ff);
   assign span       = top_ff - bottom_ff;
   assign span_short = (32'(span) < 32'(LINEAR_SPAN));
   assign bis_sum    = (CNT_W+1)'(go_up ? probe_ff : bottom_ff)
                     + (CNT_W+1)'(go_up ? top_ff : probe_ff);
   assign mid_next   = CNT_W'(bis_sum >> 1);
   assign scan_next  = probe_ff + CNT_W'(1);
   assign launch_mid = size >> 1;

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      probe_in     = probe_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = AW'(probe_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (launch.go) begin
               key_in    = launch.search_key;
               top_in    = size;
               bottom_in = '0;
               if (size == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.hit         = 1'b0;
                  rsp_in.found_value = '0;
               end else begin
                  probe_in = launch_mid;
                  rd_addr  = AW'(launch_mid);
                  state_in = ST_BISECT;
               end
            end
         end
         ST_BISECT: begin
            if (key_match) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = 1'b1;
               rsp_in.found_value = rd_value;
               state_in           = ST_IDLE;
            end else if (span_short) begin
               // The scan covers the whole remaining span, midpoint included.
               if (bottom_ff == top_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.hit         = 1'b0;
                  rsp_in.found_value = '0;
                  state_in           = ST_IDLE;
               end else begin
                  probe_in = bottom_ff;
                  rd_addr  = AW'(bottom_ff);
                  state_in = ST_SCAN;
               end
            end else begin
               // The lower bound moves to the midpoint itself.
               if (go_up) begin
                  bottom_in = probe_ff;
               end else begin
                  top_in = probe_ff;
               end
               probe_in = mid_next;
               rd_addr  = AW'(mid_next);
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = 1'b1;
               rsp_in.found_value = rd_value;
               state_in           = ST_IDLE;
            end else if (scan_next >= top_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = 1'b0;
               rsp_in.found_value = '0;
               state_in           = ST_IDLE;
            end else begin
               probe_in = scan_next;
               rd_addr  = AW'(scan_next);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
      probe_ff  <= probe_in;
      key_ff    <= key_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `STKL_ASSERT_SAME(a_rsp_when_idle, rsp_valid_ff, state_ff == ST_IDLE, "response while searching")
   `STKL_ASSERT_SAME(a_miss_is_zero, rsp_valid_ff && !rsp_ff.hit, rsp_ff.found_value == '0, "miss with nonzero value")
   `STKL_ASSERT_SAME(a_bounds_order, state_ff != ST_IDLE, bottom_ff <= top_ff, "search bounds crossed")
   `STKL_ASSERT_SAME(a_scan_in_span, state_ff == ST_SCAN, (probe_ff >= bottom_ff) && (probe_ff < top_ff), "scan probe outside span")
   `STKL_ASSERT_NEXT(a_match_answers, (state_ff == ST_BISECT) && key_match, rsp_valid_ff && rsp_ff.hit, "bisection match not answered")

endmodule

/* design/sorted_table_key_lookup_unit.sv */
// Top level of the sorted table key lookup unit: register, load path and memories.
//
// Usage:
//   A request is accepted at a rising edge with start high and busy low.
//   command = load writes search_key and entry_value at entry_index and
//   gives no response; indexes at or above TABLE_DEPTH are dropped.
//   command = lookup searches the first table_size entries (clamped to
//   TABLE_DEPTH) and answers once on rsp_valid with hit and found_value.
//   The search probes one entry per cycle from the key and value memories:
//   first bisection steps while the span holds at least LINEAR_SPAN entries,
//   then a linear scan of the rest. A lookup taking P probes keeps busy high
//   while it probes and shows its response in the cycle after the last probe;
//   with LINEAR_SPAN = 50, P is at most 56 for any size up to 4096 and at
//   most 40 for a full 4096-entry table. An empty table answers a miss in
//   the cycle after the request. busy drops together with the response, so
//   the next request may follow at once. The response lasts one cycle and
//   cannot be stalled.
//   table_size is written on the csr channel, which is always ready; write it
//   only while busy is low. Reset clears table_size and the sequencer; the
//   memories are not cleared, and entries must be loaded before they are read.
module sorted_table_key_lookup_unit #(
   parameter int TABLE_DEPTH = 4096,
   parameter int LINEAR_SPAN = 50
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  stkl_pkg::stkl_req_type        req_item,
   output logic                          rsp_valid,
   output stkl_pkg::stkl_rsp_type        rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [stkl_pkg::SIZE_W-1:0]   csr_data
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [stkl_pkg::SIZE_W-1:0]  table_size_ff, table_size_in;
   logic [CNT_W-1:0]             size_clamped;
   logic                         accept;
   logic                         load_en;
   logic [AW-1:0]                load_addr;
   logic [AW-1:0]                rd_addr;
   logic [stkl_pkg::KEY_W-1:0]   rd_key;
   logic [stkl_pkg::VALUE_W-1:0] rd_value;
   stkl_pkg::stkl_launch_type    launch;

   assign csr_ready     = 1'b1;
   assign table_size_in = (csr_valid && csr_ready) ? csr_data : table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   assign size_clamped = (32'(table_size_ff) > 32'(TABLE_DEPTH)) ?
                         CNT_W'(TABLE_DEPTH) : CNT_W'(table_size_ff);

   assign accept    = start && !busy;
   assign load_en   = accept && (req_item.command == stkl_pkg::CMD_LOAD) &&
                      (32'(req_item.entry_index) < 32'(TABLE_DEPTH));
   assign load_addr = AW'(req_item.entry_index);

   assign launch.go         = accept && (req_item.command == stkl_pkg::CMD_LOOKUP);
   assign launch.search_key = req_item.search_key;

   stkl_ram #(
      .WIDTH (stkl_pkg::KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_item.search_key),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   stkl_ram #(
      .WIDTH (stkl_pkg::VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_item.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_value)
   );

   stkl_search #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LINEAR_SPAN (LINEAR_SPAN)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .size      (size_clamped),
      .rd_key    (rd_key),
      .rd_value  (rd_value),
      .rd_addr   (rd_addr),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/sorted_table_key_lookup_unit_tb.sv */
// Self-checking testbench for the sorted table key lookup unit.

class lookup_scoreboard;
   localparam int DEPTH = 4096;
   localparam int SPAN  = 50;
   localparam int IDX_W = $clog2(DEPTH);

   logic [63:0]            key_mem   [DEPTH];
   logic [63:0]            value_mem [DEPTH];
   int unsigned            table_size;
   stkl_pkg::stkl_rsp_type expected_q[$];
   int                     failures;

   function new();
      table_size = 0;
      failures   = 0;
   endfunction

   function void set_size(logic [stkl_pkg::SIZE_W-1:0] n);
      table_size = 32'(n);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Bisect down to a short span, then scan it from low to high.
   function void search(input logic [63:0] key, output logic hit, output logic [63:0] val);
      int unsigned top;
      int unsigned bottom;
      int unsigned mid;
      top    = (table_size > DEPTH) ? DEPTH : table_size;
      bottom = 0;
      hit    = 1'b0;
      val    = '0;
      if (top == 0) return;
      mid = (top + bottom) / 2;
      while (key_mem[IDX_W'(mid)] != key) begin
         if (top - bottom < SPAN) begin
            for (int unsigned i = bottom; i < top; i++) begin
               if (key_mem[IDX_W'(i)] == key) begin
                  hit = 1'b1;
                  val = value_mem[IDX_W'(i)];
                  return;
               end
            end
            return;
         end
         // The lower bound moves to the midpoint itself.
         if (key_mem[IDX_W'(mid)] < key) bottom = mid;
         else top = mid;
         mid = (top + bottom) / 2;
      end
      hit = 1'b1;
      val = value_mem[IDX_W'(mid)];
   endfunction

   function void note_request(stkl_pkg::stkl_req_type r);
      stkl_pkg::stkl_rsp_type e;
      if (r.command == stkl_pkg::CMD_LOAD) begin
         key_mem[r.entry_index]   = r.search_key;
         value_mem[r.entry_index] = r.entry_value;
      end else begin
         search(r.search_key, e.hit, e.found_value);
         expected_q = {expected_q, e};
      end
   endfunction

   function void check_response(stkl_pkg::stkl_rsp_type r);
      stkl_pkg::stkl_rsp_type e;
      if (expected_q.size() == 0) begin
         $error("response with no lookup outstanding: hit %0b value %h", r.hit, r.found_value);
         failures++;
         return;
      end
      e = expected_q.pop_front();
      if (r.hit !== e.hit) begin
         $error("hit: expected %0b, actual %0b", e.hit, r.hit);
         failures++;
      end
      if (r.found_value !== e.found_value) begin
         $error("found_value: expected %h, actual %h", e.found_value, r.found_value);
         failures++;
      end
   endfunction
endclass

module sorted_table_key_lookup_unit_tb;

   localparam int CLOCK_PERIOD   = 10;
   localparam int TABLE_DEPTH    = 4096;
   localparam int IDX_W          = $clog2(TABLE_DEPTH);
   localparam int REQ_W          = $bits(stkl_pkg::stkl_req_type);
   localparam int SETTLE_CYCLES  = 70;
   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int PHASE_LOOKUPS  = 35;

   typedef enum {TBL_SORTED, TBL_EXTREME, TBL_DUPLICATE, TBL_SHUFFLED} table_kind_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   stkl_pkg::stkl_req_type        req_item;
   logic                          rsp_valid;
   stkl_pkg::stkl_rsp_type        rsp_item;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [stkl_pkg::SIZE_W-1:0]   csr_data;

   lookup_scoreboard sb;
   int               sender_idle_pct;
   int               loaded_upto;

   sorted_table_key_lookup_unit #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .LINEAR_SPAN(50)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_response(rsp_item);
         if (start && !busy) sb.note_request(req_item);
         if (csr_valid && csr_ready) sb.set_size(csr_data);
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken,
   // with start still high so that a following request can go out back to back.
   task issue_request(input stkl_pkg::stkl_req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start = 1'b0;
         req_item = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         @(negedge clock);
      end
      start    = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task load_entry(input int idx, input logic [63:0] key, input logic [63:0] val);
      stkl_pkg::stkl_req_type r;
      r.command     = stkl_pkg::CMD_LOAD;
      r.entry_index = idx[stkl_pkg::INDEX_W-1:0];
      r.search_key  = key;
      r.entry_value = val;
      issue_request(r);
   endtask

   task lookup_key(input logic [63:0] key);
      stkl_pkg::stkl_req_type r;
      r.command     = stkl_pkg::CMD_LOOKUP;
      r.entry_index = IDX_W'($urandom);
      r.search_key  = key;
      r.entry_value = {$urandom, $urandom};
      issue_request(r);
   endtask

   // A load gives no response, so let a possible search finish before the write.
   task write_table_size(input int unsigned n);
      start = 1'b0;
      while (sb.pending() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = n[stkl_pkg::SIZE_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task build_table(input int n, input table_kind_type kind);
      logic [63:0] key;
      logic [63:0] step;
      logic [63:0] val;
      key = (kind == TBL_EXTREME) ? 64'd0 : ({$urandom, $urandom} >> 2);
      for (int i = 0; i < n; i++) begin
         if (kind == TBL_SHUFFLED) begin
            key = {$urandom, $urandom};
         end else if (i > 0) begin
            // Steps are at most 2**50, so a full table cannot wrap past the top key.
            step = {$urandom, $urandom} >> $urandom_range(14, 63);
            if (kind == TBL_DUPLICATE && $urandom_range(0, 2) == 0) step = 64'd0;
            else step = step + 64'd1;
            key = key + step;
         end
         if (kind == TBL_EXTREME && n > 1 && i == n - 1) key = '1;
         val = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
         load_entry(i, key, val);
      end
      if (n > loaded_upto) loaded_upto = n;
   endtask

   task run_lookups(input int active, input int count);
      int          done;
      int          pick;
      int          idx;
      logic [63:0] key;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95) begin
            // Overwriting a loaded entry keeps every probe on written storage.
            if (loaded_upto == 0) loaded_upto = 1;
            idx = $urandom_range(0, loaded_upto - 1);
            load_entry(idx, {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            if (active > 0 && pick < 75) begin
               key = sb.key_mem[IDX_W'($urandom_range(0, active - 1))];
               if (pick >= 60) key = $urandom_range(0, 1) ? key + 64'd1 : key - 64'd1;
            end else if (pick >= 90) begin
               key = '1;
            end else if (pick >= 85) begin
               key = 64'd0;
            end else begin
               key = {$urandom, $urandom};
            end
            lookup_key(key);
            done++;
         end
      end
   endtask

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int             phase_sizes[20];
      int             idle_levels[4];
      int             active;
      table_kind_type kind;
      int             pick;
      logic [63:0]    probe_key;

      sb              = new();
      sender_idle_pct = 0;
      loaded_upto     = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_item        = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, a one-entry table holding a zero value, and the key extremes.
      write_table_size(0);
      lookup_key(64'd0);
      lookup_key('1);
      load_entry(0, 64'd0, 64'd0);
      write_table_size(1);
      lookup_key(64'd0);
      lookup_key('1);
      load_entry(0, 64'd0, '1);
      load_entry(1, 64'd5, 64'd0);
      load_entry(2, '1, {$urandom, $urandom});
      loaded_upto = 3;
      write_table_size(3);
      lookup_key(64'd0);
      lookup_key(64'd5);
      lookup_key('1);
      lookup_key(64'd3);
      lookup_key(64'd6);

      // Sizes at and above the depth probe the middle entry first, so a key stored
      // there answers at once and shows whether the size is clamped.
      probe_key = {$urandom, $urandom};
      load_entry(TABLE_DEPTH / 2, probe_key, {$urandom, $urandom});
      write_table_size(8191);
      lookup_key(probe_key);
      write_table_size(4097);
      lookup_key(probe_key);
      write_table_size(4096);
      lookup_key(probe_key);

      phase_sizes = '{1, 2, 3, 49, 50, 51, 52, 99, 100, 101, 300,
                      $urandom_range(4, 300), $urandom_range(4, 300),
                      $urandom_range(4, 300), $urandom_range(4, 300),
                      299, 150, 65, 0, 64};
      idle_levels = '{0, 59, 0, 29};

      for (int p = 0; p < 20; p++) begin
         sender_idle_pct = idle_levels[p % 4];
         write_table_size(phase_sizes[p]);
         active = (phase_sizes[p] > TABLE_DEPTH) ? TABLE_DEPTH : phase_sizes[p];
         if (active > loaded_upto || active <= 64) begin
            pick = $urandom_range(0, 9);
            if (active > 512) kind = TBL_EXTREME;
            else if (pick < 6) kind = TBL_SORTED;
            else if (pick < 8) kind = TBL_EXTREME;
            else if (pick < 9) kind = TBL_DUPLICATE;
            else kind = TBL_SHUFFLED;
            build_table(active, kind);
         end
         run_lookups(active, PHASE_LOOKUPS);
      end

      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+design
design/stkl_pkg.sv
design/stkl_ram.sv
design/stkl_search.sv
design/sorted_table_key_lookup_unit.sv
tb/sorted_table_key_lookup_unit_tb.sv
